FILE: hw/rtl/elevator_sweep_scheduler_core_assert.svh
// Assertion macros for the scheduler core.
`ifndef ELEVATOR_SWEEP_SCHEDULER_CORE_ASSERT_SVH
`define ELEVATOR_SWEEP_SCHEDULER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ESS_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ESS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ESS_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ESS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

FILE: hw/rtl/ess_pkg.sv
package ess_pkg;
    localparam int QueueDepth = 16;
    localparam int IdxW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    localparam logic [1:0] FUNC_ADD_UP   = 2'd0;
    localparam logic [1:0] FUNC_ADD_DOWN = 2'd1;
    localparam logic [1:0] FUNC_OPERATE  = 2'd2;
    localparam logic [1:0] FUNC_EMERG    = 2'd3;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_STOP  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_EMERG = 2'd3;

    typedef struct packed {
        logic       latch_in;   // capture the input word
        logic       ins_start;  // begin a shift step for one insert
        logic       ins_pickup; // value to insert is the pickup floor
        logic       ins_shift;  // move the entry below the slot up by one
        logic       ins_write;  // write the value at the found slot
        logic       drain_rd;   // issue read of drain entry
        logic       drain_use;  // registered drain data is valid
        logic       emerg;      // apply emergency
        logic       clr_up;
        logic       clr_down;
        logic       drain_down; // drain the down queue
        logic       drain_rst;  // reset drain index
    } t_cmd;

    typedef struct packed {
        logic            up_sel;
        logic            outside;
        logic            fits;
        logic            shift_done;
        logic            drain_end;
        logic            drain_skip;
    } t_sts;
endpackage

FILE: hw/rtl/ess_ctrl.sv
module ess_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_func,
    input  logic          i_out_stall,
    input  ess_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output logic [1:0]    o_kind,
    output logic          o_full,
    output logic          o_last,
    output ess_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_INS1  = 4'd2;
    localparam logic [3:0] S_INS2  = 4'd3;
    localparam logic [3:0] S_DRD   = 4'd4;
    localparam logic [3:0] S_DUSE  = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_SHFT1 = 4'd7;
    localparam logic [3:0] S_SHFT2 = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_func;
    logic       r_down, n_down;
    logic       r_ov, n_ov;
    logic [1:0] r_kind, n_kind;
    logic       r_full, n_full, r_last, n_last;
    logic       out_free;

    assign out_free   = !r_ov || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_kind = r_kind;
    assign o_full = r_full;
    assign o_last = r_last;

    always_comb begin
        n_state = r_state;
        n_down  = r_down;
        n_ov    = r_ov && i_out_stall;
        n_kind  = r_kind;
        n_full  = r_full;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_func == ess_pkg::FUNC_OPERATE) begin
                    o_cmd.drain_rst = 1'b1;
                    n_down = 1'b0;
                    n_state = S_DRD;
                end else if (r_func == ess_pkg::FUNC_EMERG) begin
                    if (out_free) begin
                        o_cmd.emerg = 1'b1;
                        n_ov = 1'b1; n_kind = ess_pkg::KIND_EMERG;
                        n_full = 1'b0; n_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (!i_sts.fits) begin
                    if (out_free) begin
                        n_ov = 1'b1; n_kind = ess_pkg::KIND_ACK;
                        n_full = 1'b1; n_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_sts.outside) begin
                    o_cmd.ins_start = 1'b1;
                    o_cmd.ins_pickup = 1'b1;
                    n_state = S_SHFT1;
                end else begin
                    o_cmd.ins_start = 1'b1;
                    n_state = S_SHFT2;
                end
            end
            S_SHFT1: begin
                o_cmd.ins_pickup = 1'b1;
                if (i_sts.shift_done) begin
                    o_cmd.ins_write = 1'b1;
                    n_state = S_INS2;
                end else begin
                    o_cmd.ins_shift = 1'b1;
                end
            end
            S_INS2: begin
                o_cmd.ins_start = 1'b1;
                n_state = S_SHFT2;
            end
            S_SHFT2: begin
                if (i_sts.shift_done) begin
                    o_cmd.ins_write = 1'b1;
                    n_state = S_INS1;
                end else begin
                    o_cmd.ins_shift = 1'b1;
                end
            end
            S_INS1: begin
                if (out_free) begin
                    n_ov = 1'b1; n_kind = ess_pkg::KIND_ACK;
                    n_full = 1'b0; n_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DRD: begin
                o_cmd.drain_down = r_down;
                if (i_sts.drain_end) begin
                    if (!r_down) begin
                        o_cmd.clr_up = 1'b1;
                        o_cmd.drain_rst = 1'b1;
                        n_down = 1'b1;
                    end else if (out_free) begin
                        o_cmd.clr_down = 1'b1;
                        n_ov = 1'b1; n_kind = ess_pkg::KIND_DONE;
                        n_full = 1'b0; n_last = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.drain_rd = 1'b1;
                    n_state = S_DUSE;
                end
            end
            S_DUSE: begin
                o_cmd.drain_down = r_down;
                if (i_sts.drain_skip) begin
                    o_cmd.drain_use = 1'b1;
                    n_state = S_DRD;
                end else if (out_free) begin
                    o_cmd.drain_use = 1'b1;
                    n_ov = 1'b1; n_kind = ess_pkg::KIND_STOP;
                    n_full = 1'b0; n_last = 1'b0;
                    n_state = S_DRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_down  <= 1'b0;
            r_func  <= ess_pkg::FUNC_ADD_UP;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_down  <= n_down;
            if (o_cmd.latch_in) begin
                r_func <= i_func;
            end
        end
        r_kind <= n_kind;
        r_full <= n_full;
        r_last <= n_last;
    end
endmodule

FILE: hw/rtl/ess_dp.sv
module ess_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [1:0]    i_func,
    input  logic          i_from_outside,
    input  logic [7:0]    i_pickup_floor,
    input  logic [7:0]    i_target_floor,
    input  logic          i_home_we,
    input  logic [7:0]    i_home_floor,
    input  ess_pkg::t_cmd i_cmd,
    output ess_pkg::t_sts o_sts,
    output logic [7:0]    o_car_floor,
    output logic          o_doors_open,
    output logic          o_in_emergency
);
    localparam int DW = ess_pkg::QueueDepth;
    localparam int IW = ess_pkg::IdxW;
    localparam int CW = ess_pkg::CntW;

    logic [7:0]    r_upq [DW];
    logic [7:0]    r_dnq [DW];
    logic [CW-1:0] r_upc, r_dnc;
    logic [7:0]    r_home, r_floor;
    logic          r_door, r_emg;
    logic          r_up, r_out;
    logic [7:0]    r_pick, r_tgt;
    logic [CW-1:0] r_pos;     // insert: shifting slot, counts down
    logic [CW-1:0] r_didx;
    logic [7:0]    r_drd;
    logic [7:0]    r_shv;     // entry below r_pos
    logic [7:0]    ins_val;
    logic [CW-1:0] cnt, need;
    logic          below_ok;

    assign ins_val = i_cmd.ins_pickup ? r_pick : r_tgt;
    assign cnt  = r_up ? r_upc : r_dnc;
    assign need = r_out ? CW'(2) : CW'(1);
    // Entry at r_pos-1 stays below the new value when order holds.
    assign below_ok = (r_pos == '0) ||
        (r_up ? (r_shv <= ins_val) : (r_shv >= ins_val));

    assign o_sts.up_sel     = r_up;
    assign o_sts.outside    = r_out;
    assign o_sts.fits       = ({1'b0, cnt} + {1'b0, need}) <= (CW+1)'(DW);
    assign o_sts.shift_done = below_ok;
    assign o_sts.drain_end  = r_didx >= (i_cmd.drain_down ? r_dnc : r_upc);
    assign o_sts.drain_skip = (r_drd == r_floor);

    assign o_car_floor    = r_floor;
    assign o_doors_open   = r_door;
    assign o_in_emergency = r_emg;

    // One shift per cycle: read slot r_pos-1, move it up if it must go above the value.
    always_ff @(posedge i_clk) begin
        logic [IW-1:0] rd;
        rd = IW'(r_pos - CW'(1));
        if (i_cmd.ins_start) begin
            r_pos <= cnt;
            r_shv <= r_up ? r_upq[IW'(cnt - CW'(1))] : r_dnq[IW'(cnt - CW'(1))];
        end else if (i_cmd.ins_shift) begin
            if (r_up) r_upq[IW'(r_pos)] <= r_shv;
            else      r_dnq[IW'(r_pos)] <= r_shv;
            r_pos <= r_pos - CW'(1);
            r_shv <= r_up ? r_upq[IW'(rd - IW'(1))] : r_dnq[IW'(rd - IW'(1))];
        end
        if (i_cmd.ins_write) begin
            if (r_up) r_upq[IW'(r_pos)] <= ins_val;
            else      r_dnq[IW'(r_pos)] <= ins_val;
        end
        if (i_cmd.drain_rd) begin
            r_drd <= i_cmd.drain_down ? r_dnq[IW'(r_didx)] : r_upq[IW'(r_didx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= '0; r_dnc <= '0;
            r_home <= 8'd1; r_floor <= 8'd1;
            r_door <= 1'b0; r_emg <= 1'b0;
            r_didx <= '0;
        end else begin
            if (i_home_we) r_home <= i_home_floor;
            if (i_cmd.ins_write) begin
                if (r_up) r_upc <= r_upc + CW'(1);
                else      r_dnc <= r_dnc + CW'(1);
            end
            if (i_cmd.drain_rst) r_didx <= '0;
            else if (i_cmd.drain_rd) r_didx <= r_didx + CW'(1);
            if (i_cmd.drain_use && !o_sts.drain_skip) begin
                r_floor <= r_drd;
                r_door  <= 1'b0;
            end
            if (i_cmd.clr_up) r_upc <= '0;
            if (i_cmd.clr_down) r_dnc <= '0;
            if (i_cmd.emerg) begin
                r_upc <= '0; r_dnc <= '0;
                r_floor <= r_home; r_door <= 1'b1; r_emg <= 1'b1;
            end
        end
        if (i_cmd.latch_in) begin
            r_up   <= (i_func == ess_pkg::FUNC_ADD_UP);
            r_out  <= i_from_outside;
            r_pick <= i_pickup_floor;
            r_tgt  <= i_target_floor;
        end
    end
endmodule

FILE: hw/rtl/elevator_sweep_scheduler_core.sv
// Elevator sweep scheduler. Add requests insert floors into a sorted up or down
// queue of 16 entries by moving one entry per cycle. An inside add inserts its
// target floor, an outside add inserts its pickup floor and then its target
// floor, and an add that does not fit is acknowledged with the full flag set.
// Operate reads the up queue and then the down queue one entry at a time,
// emitting a stop word for each entry that moves the car, then a done word with
// last set. One word is handled at a time; the input stalls until the final
// result is registered, and the output register lets that word wait while the
// next input word is taken. Any cycle in which a result word is still held by
// the output stall delays the next word that must be registered.
`include "elevator_sweep_scheduler_core_assert.svh"
module elevator_sweep_scheduler_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_func,
    input  logic       i_from_outside,
    input  logic [7:0] i_pickup_floor,
    input  logic [7:0] i_target_floor,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic       o_queue_full,
    output logic [7:0] o_car_floor,
    output logic       o_doors_open,
    output logic       o_in_emergency,
    output logic       o_last
);
    ess_pkg::t_cmd cmd;
    ess_pkg::t_sts sts;
    logic [7:0] car;
    logic       door, emg;

    // The controller sequences every item; the datapath owns queues and car state.
    ess_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_func(i_func),
        .i_out_stall(i_stall), .i_sts(sts), .o_in_stall(o_stall),
        .o_out_valid(o_valid), .o_kind(o_kind), .o_full(o_queue_full),
        .o_last(o_last), .o_cmd(cmd)
    );

    ess_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_func(i_func),
        .i_from_outside(i_from_outside), .i_pickup_floor(i_pickup_floor),
        .i_target_floor(i_target_floor), .i_home_we(i_cfg_we),
        .i_home_floor(i_cfg_data), .i_cmd(cmd), .o_sts(sts),
        .o_car_floor(car), .o_doors_open(door), .o_in_emergency(emg)
    );

    // The car state changes only at the edge that registers a new result word, and
    // that edge waits until the previous word has left. The datapath values are
    // therefore presented directly and stay fixed while a word is stalled.
    assign o_car_floor    = car;
    assign o_doors_open   = door;
    assign o_in_emergency = emg;

    `ESS_ASSERT_NEVER(a_stall_idle_out, i_clk, i_rst_n,
        o_valid && o_queue_full && (o_kind != ess_pkg::KIND_ACK), "full on non-ack")
    `ESS_ASSERT_NEVER(a_emg_sticky, i_clk, i_rst_n,
        $fell(o_in_emergency), "emergency flag cleared")
    `ESS_ASSERT_NEVER(a_stop_last, i_clk, i_rst_n,
        o_valid && o_last && (o_kind == ess_pkg::KIND_STOP), "stop with last")
endmodule
